### design/matrix_multiply_engine_assert.svh
// ----------------------------------------------------------------------------
// Matrix multiply engine assertion macros
// Shorthand for clocked checks, reset-qualified, used by the engine RTL.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ENGINE_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_ASSERT_SVH

// same-cycle implication check
`define MME_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// next-cycle implication check
`define MME_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### design/mme_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply engine package
// Sizes, word types, command and register codes, dimension clamp.
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int MAX_DIM   = 8;
  localparam int ELEM_BITS = 16;

  localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = 2 ** ADDR_W;
  localparam int PROD_W    = 2 * ELEM_BITS;

  localparam int CMD_W     = 2;
  localparam int POS_W     = 3;
  localparam int VALUE_W   = 16;
  localparam int SUM_W     = 40;
  localparam int CFG_W     = 4;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(8);

  localparam logic [CFG_ADDR_W-1:0] REG_PROD_ROWS = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_INNER_DIM = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_PROD_COLS = CFG_ADDR_W'(2);

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_LEFT  = 2'd0,
    CMD_WR_RIGHT = 2'd1,
    CMD_MULTIPLY = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic [POS_W-1:0]          row;
    logic [POS_W-1:0]          col;
    logic signed [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic                    status;
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic signed [SUM_W-1:0] sum;
    logic                    last;
  } out_word_t;

  // control riding along the multiply pipeline
  typedef struct packed {
    logic             first;
    logic             lastk;
    logic             run_last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  function automatic logic [CFG_W-1:0] dim_clamp(input logic [CFG_W-1:0] raw);
    logic [CFG_W-1:0] d;
    d = raw;
    if (raw == '0) begin
      d = CFG_W'(1);
    end else if (raw > CFG_W'(MAX_DIM)) begin
      d = CFG_W'(MAX_DIM);
    end
    return d;
  endfunction

endpackage

### design/matrix_multiply_engine.sv
// ----------------------------------------------------------------------------
// Matrix multiply engine
// Signed Q8.8 left and right element stores with a multiply-accumulate
// sequencer that streams the Q24.16 product row by row.
// ----------------------------------------------------------------------------
// Element writes may arrive back to back unless a finished word is held by
// out_stall; each returns one status word. A multiply command steps through
// every product row, product column and inner index with a single
// multiplier and accumulator, one store read port each, and the pipeline
// freezes on any cycle a finished word is held by out_stall. The engine
// takes no new word while a multiply is in flight. Stores read as zero after
// reset through per-entry valid flags, so no clearing pass is needed.
`include "matrix_multiply_engine_assert.svh"

module matrix_multiply_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mme_pkg::in_word_t                   in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mme_pkg::out_word_t                  out_word,
  input  logic                                cfg_we,
  input  logic [mme_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [mme_pkg::CFG_W-1:0]           cfg_wdata
);
  import mme_pkg::*;

  logic [CFG_W-1:0] prod_rows_r, inner_dim_r, prod_cols_r;
  logic [CFG_W-1:0] nr, nk, nc;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic             issue;
  tag_t             tag;

  logic             s1_v_r, s1_lv_r, s1_rv_r;
  tag_t             s1_tag_r;
  logic             s2_v_r;
  tag_t             s2_tag_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  acc_r, acc_nxt;

  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  logic [DEPTH-1:0] left_vld_r, right_vld_r;
  logic [ADDR_W-1:0] waddr, laddr, raddr;
  logic [ELEM_BITS-1:0] wdata, l_rdata, r_rdata;
  logic signed [ELEM_BITS-1:0] a_op, b_op;

  logic freeze, in_fire, is_wr, wr_left, wr_right, in_bounds;
  logic [CFG_W-1:0] rows_ok, cols_ok;

  assign nr = dim_clamp(prod_rows_r);
  assign nk = dim_clamp(inner_dim_r);
  assign nc = dim_clamp(prod_cols_r);

  assign freeze   = out_valid_r && out_stall;
  assign in_stall = (state_r != ST_IDLE) || freeze;
  assign in_fire  = in_valid && !in_stall;

  // element write path
  assign is_wr     = (in_word.cmd == CMD_WR_LEFT) || (in_word.cmd == CMD_WR_RIGHT);
  assign rows_ok   = (in_word.cmd == CMD_WR_LEFT) ? nr : nk;
  assign cols_ok   = (in_word.cmd == CMD_WR_LEFT) ? nk : nc;
  assign in_bounds = (CFG_W'(in_word.row) < rows_ok) && (CFG_W'(in_word.col) < cols_ok);
  assign wr_left   = in_fire && (in_word.cmd == CMD_WR_LEFT) && in_bounds;
  assign wr_right  = in_fire && (in_word.cmd == CMD_WR_RIGHT) && in_bounds;
  assign waddr     = {in_word.row[IDX_W-1:0], in_word.col[IDX_W-1:0]};
  assign wdata     = ELEM_BITS'(in_word.value);

  assign laddr = {i_r, k_r};
  assign raddr = {k_r, j_r};

  mme_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (wr_left),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue),
    .raddr (laddr),
    .rdata (l_rdata)
  );

  mme_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_right_ram (
    .clk   (clk),
    .we    (wr_right),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue),
    .raddr (raddr),
    .rdata (r_rdata)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_rows_r <= DIM_RESET;
      inner_dim_r <= DIM_RESET;
      prod_cols_r <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PROD_ROWS: prod_rows_r <= cfg_wdata;
        REG_INNER_DIM: inner_dim_r <= cfg_wdata;
        REG_PROD_COLS: prod_cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // store valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_vld_r  <= '0;
      right_vld_r <= '0;
    end else begin
      if (wr_left) begin
        left_vld_r[waddr] <= 1'b1;
      end
      if (wr_right) begin
        right_vld_r[waddr] <= 1'b1;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    issue        = 1'b0;
    tag.first    = (k_r == '0);
    tag.lastk    = ((CFG_W'(k_r) + CFG_W'(1)) == nk);
    tag.run_last = ((CFG_W'(i_r) + CFG_W'(1)) == nr) &&
                   ((CFG_W'(j_r) + CFG_W'(1)) == nc);
    tag.row      = i_r;
    tag.col      = j_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_word.cmd == CMD_MULTIPLY)) begin
          state_nxt = ST_RUN;
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_RUN: begin
        if (!freeze) begin
          issue = 1'b1;
          if (tag.lastk) begin
            k_nxt = '0;
            if ((CFG_W'(j_r) + CFG_W'(1)) == nc) begin
              j_nxt = '0;
              if (tag.run_last) begin
                state_nxt = ST_DRAIN;
              end else begin
                i_nxt = i_r + IDX_W'(1);
              end
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end else begin
            k_nxt = k_r + IDX_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (!s1_v_r && !s2_v_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // multiply-accumulate pipeline
  assign a_op    = s1_lv_r ? l_rdata : '0;
  assign b_op    = s1_rv_r ? r_rdata : '0;
  assign acc_nxt = (s2_tag_r.first ? '0 : acc_r) + SUM_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (!freeze) begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!freeze) begin
      s1_tag_r <= tag;
      s1_lv_r  <= left_vld_r[laddr];
      s1_rv_r  <= right_vld_r[raddr];
      s2_tag_r <= s1_tag_r;
      prod_r   <= a_op * b_op;
      if (s2_v_r) begin
        acc_r <= acc_nxt;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (!freeze) begin
      out_valid_nxt = 1'b0;
      if (s2_v_r && s2_tag_r.lastk) begin
        out_valid_nxt        = 1'b1;
        out_word_nxt.status  = 1'b0;
        out_word_nxt.out_row = POS_W'(s2_tag_r.row);
        out_word_nxt.out_col = POS_W'(s2_tag_r.col);
        out_word_nxt.sum     = acc_nxt;
        out_word_nxt.last    = s2_tag_r.run_last;
      end else if (in_fire && is_wr) begin
        out_valid_nxt        = 1'b1;
        out_word_nxt.status  = !in_bounds;
        out_word_nxt.out_row = '0;
        out_word_nxt.out_col = '0;
        out_word_nxt.sum     = '0;
        out_word_nxt.last    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `MME_ASSERT(a_idle_pipe_empty, (state_r == ST_IDLE) |-> (!s1_v_r && !s2_v_r), "pipeline busy while idle")
  `MME_ASSERT(a_run_idx_range, (state_r == ST_RUN) |-> ((CFG_W'(i_r) < nr) && (CFG_W'(j_r) < nc) && (CFG_W'(k_r) < nk)), "index past dimension")
  `MME_ASSERT(a_status_not_last, (out_valid_r && out_word_r.status) |-> !out_word_r.last, "error word marked last")
  `MME_ASSERT_NEXT(a_last_ends_run, out_valid_r && out_word_r.last, !s1_v_r && !s2_v_r, "run not finished after last word")

endmodule

### design/mme_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### bench/mme_checker.sv
// ----------------------------------------------------------------------------
// Matrix multiply engine checker
// Watches the command, result and register ports of the engine. It keeps its
// own copy of both element stores and the dimension registers, works out the
// status or product words that each accepted command word should bring, and
// compares every accepted result word field by field, in order.
// ----------------------------------------------------------------------------
module mme_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  mme_pkg::in_word_t              in_word,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  mme_pkg::out_word_t             out_word,
  input  logic                           cfg_we,
  input  logic [mme_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mme_pkg::CFG_W-1:0]      cfg_wdata,
  output int                             fail_count,
  output int                             pending,
  output int                             checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import mme_pkg::*;

  logic signed [VALUE_W-1:0] left_elems  [MAX_DIM*MAX_DIM];
  logic signed [VALUE_W-1:0] right_elems [MAX_DIM*MAX_DIM];
  logic [CFG_W-1:0]          rows_reg;
  logic [CFG_W-1:0]          inner_reg;
  logic [CFG_W-1:0]          cols_reg;
  out_word_t                 awaited_words[$];
  int                        errors = 0;
  int                        seen = 0;

  function automatic int dim_used(logic [CFG_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_DIM) return MAX_DIM;
    return int'(raw);
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // status word for a store write, or the whole product for a multiply
  task automatic predict_word(in_word_t w);
    int nr, nk, nc, i, j, k, addr;
    logic signed [SUM_W-1:0] acc;
    out_word_t r;
    nr = dim_used(rows_reg);
    nk = dim_used(inner_reg);
    nc = dim_used(cols_reg);
    r = '0;
    addr = int'(w.row) * MAX_DIM + int'(w.col);
    case (w.cmd)
      CMD_WR_LEFT: begin
        r.status = !(int'(w.row) < nr && int'(w.col) < nk);
        if (!r.status) left_elems[addr] = w.value;
        awaited_words.push_back(r);
      end
      CMD_WR_RIGHT: begin
        r.status = !(int'(w.row) < nk && int'(w.col) < nc);
        if (!r.status) right_elems[addr] = w.value;
        awaited_words.push_back(r);
      end
      CMD_MULTIPLY: begin
        for (i = 0; i < nr; i++) begin
          for (j = 0; j < nc; j++) begin
            acc = '0;
            for (k = 0; k < nk; k++) begin
              acc = acc + left_elems[i*MAX_DIM+k] * right_elems[k*MAX_DIM+j];
            end
            r = '0;
            r.out_row = POS_W'(i);
            r.out_col = POS_W'(j);
            r.sum     = acc;
            r.last    = (i == nr - 1) && (j == nc - 1);
            awaited_words.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      foreach (left_elems[n]) begin
        left_elems[n]  = '0;
        right_elems[n] = '0;
      end
      rows_reg  = DIM_RESET;
      inner_reg = DIM_RESET;
      cols_reg  = DIM_RESET;
      awaited_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_PROD_ROWS: rows_reg  = cfg_wdata;
          REG_INNER_DIM: inner_reg = cfg_wdata;
          REG_PROD_COLS: cols_reg  = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        seen++;
        if (awaited_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %p", out_word));
        end else begin
          want = awaited_words.pop_front();
          if (out_word.status !== want.status)
            report_mismatch($sformatf("status %b, want %b", out_word.status, want.status));
          if (out_word.out_row !== want.out_row)
            report_mismatch($sformatf("row %0d, want %0d", out_word.out_row, want.out_row));
          if (out_word.out_col !== want.out_col)
            report_mismatch($sformatf("col %0d, want %0d", out_word.out_col, want.out_col));
          if (out_word.sum !== want.sum)
            report_mismatch($sformatf("sum %0d, want %0d at (%0d,%0d)",
                                      out_word.sum, want.sum, want.out_row, want.out_col));
          if (out_word.last !== want.last)
            report_mismatch($sformatf("last %b, want %b at (%0d,%0d)",
                                      out_word.last, want.last, want.out_row, want.out_col));
        end
      end
      if (in_valid && !in_stall) predict_word(in_word);
    end
    fail_count <= errors;
    pending    <= awaited_words.size();
    checked    <= seen;
  end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Matrix multiply engine testbench
// Loads both element stores, including rejected out-of-range writes, and
// runs multiplies under a range of dimension settings, the clamped extremes
// among them, with random gaps on the command side and random stalls on
// the result side. The checker module judges every result word.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mme_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_word;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0]      cfg_wdata;
  int                    fail_count;
  int                    pending;
  int                    checked;

  bit                    src_idle = 1'b0;
  bit                    snk_idle = 1'b0;
  logic [CFG_W-1:0]      rows_cfg = DIM_RESET;
  logic [CFG_W-1:0]      inner_cfg = DIM_RESET;
  logic [CFG_W-1:0]      cols_cfg = DIM_RESET;
  int                    words_sent = 0;
  int                    mults_sent = 0;

  matrix_multiply_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  mme_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #15ms;
    $display("timeout with %0d result words outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random stall before each word while snk_idle is set
  initial begin
    int gap;
    out_stall <= 1'b0;
    forever begin
      gap = snk_idle ? $urandom_range(0, 18) : 0;
      if (gap == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  function automatic int eff_dim(logic [CFG_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_DIM) return MAX_DIM;
    return int'(raw);
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return VALUE_W'($urandom_range(0, 511) - 256);
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic in_word_t make_word(cmd_t c, int r, int col,
                                         logic signed [VALUE_W-1:0] v);
    in_word_t w;
    w.cmd   = c;
    w.row   = POS_W'(r);
    w.col   = POS_W'(col);
    w.value = v;
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    int gap;
    gap = src_idle ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    words_sent++;
    if (w.cmd == CMD_MULTIPLY) mults_sent++;
  endtask

  task automatic send_multiply();
    send_word(make_word(CMD_MULTIPLY, $urandom_range(0, 7), $urandom_range(0, 7),
                        rand_value()));
  endtask

  // wait for every result, then let the engine fall idle
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_dims(int nr, int nk, int nc);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_PROD_ROWS;
    cfg_wdata <= CFG_W'(nr);
    @(posedge clk);
    cfg_addr  <= REG_INNER_DIM;
    cfg_wdata <= CFG_W'(nk);
    @(posedge clk);
    cfg_addr  <= REG_PROD_COLS;
    cfg_wdata <= CFG_W'(nc);
    @(posedge clk);
    cfg_we    <= 1'b0;
    rows_cfg  = CFG_W'(nr);
    inner_cfg = CFG_W'(nk);
    cols_cfg  = CFG_W'(nc);
  endtask

  initial begin
    int p, count, pick;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full size: extreme elements, sum beyond 32 bits
    send_word(make_word(CMD_WR_LEFT, 0, 0, -16'sd32768));
    send_word(make_word(CMD_WR_LEFT, 0, 7, -16'sd32768));
    send_word(make_word(CMD_WR_RIGHT, 0, 0, -16'sd32768));
    send_word(make_word(CMD_WR_RIGHT, 7, 0, -16'sd32768));
    send_word(make_word(CMD_WR_LEFT, 7, 7, 16'sd32767));
    send_word(make_word(CMD_WR_RIGHT, 7, 7, 16'sd32767));
    send_word(make_word(CMD_WR_RIGHT, 7, 5, -16'sd1));
    send_word(make_word(CMD_WR_LEFT, 5, 3, 16'sd1));
    send_word(make_word(CMD_NONE, 7, 7, -16'sd1));
    send_multiply();
    settle();

    // small shape: each bound rejects a write
    set_dims(3, 5, 2);
    send_word(make_word(CMD_WR_LEFT, 3, 0, 16'sd100));
    send_word(make_word(CMD_WR_LEFT, 0, 5, 16'sd100));
    send_word(make_word(CMD_WR_RIGHT, 5, 0, 16'sd100));
    send_word(make_word(CMD_WR_RIGHT, 0, 2, 16'sd100));
    send_word(make_word(CMD_WR_LEFT, 2, 4, -16'sd32768));
    send_word(make_word(CMD_WR_RIGHT, 4, 1, 16'sd32767));
    send_multiply();
    settle();

    // zero reads as one, above eight reads as eight
    set_dims(0, 15, 9);
    send_word(make_word(CMD_WR_LEFT, 1, 0, 16'sd7));
    send_word(make_word(CMD_WR_LEFT, 0, 7, 16'sd256));
    send_multiply();
    settle();

    // hidden entries come back once the bounds grow
    set_dims(8, 8, 8);
    send_multiply();

    for (p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: set_dims(8, 8, 8);
        1: set_dims(1, 1, 1);
        2: set_dims(15, 0, 9);
        default: set_dims($urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 15));
      endcase
      src_idle = ($urandom_range(0, 3) != 0);
      snk_idle = ($urandom_range(0, 3) != 0);
      count = 0;
      while (count < 23) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          send_word(make_word(CMD_WR_LEFT, $urandom_range(0, eff_dim(rows_cfg) - 1),
                              $urandom_range(0, eff_dim(inner_cfg) - 1), rand_value()));
          count++;
        end else if (pick < 75) begin
          send_word(make_word(CMD_WR_RIGHT, $urandom_range(0, eff_dim(inner_cfg) - 1),
                              $urandom_range(0, eff_dim(cols_cfg) - 1), rand_value()));
          count++;
        end else if (pick < 85) begin
          send_word(make_word($urandom_range(0, 1) ? CMD_WR_RIGHT : CMD_WR_LEFT,
                              $urandom_range(0, 7), $urandom_range(0, 7), rand_value()));
          count++;
        end else if (pick < 92) begin
          send_word(make_word(CMD_NONE, $urandom_range(0, 7), $urandom_range(0, 7),
                              rand_value()));
        end else begin
          send_multiply();
          count++;
        end
      end
    end

    settle();
    repeat (20) @(posedge clk);
    $display("sent %0d command words, %0d of them multiplies, over ten dimension settings",
             words_sent, mults_sent);
    $display("checked %0d result words, %0d mismatches", checked, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
